### rtl/core/timed_event_queue_unit_assert.svh
// ----------------------------------------------------------------------------
// Timed event queue assertion macros
// Implication and next-cycle checks, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TIMED_EVENT_QUEUE_UNIT_ASSERT_SVH
`define TIMED_EVENT_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define TEQU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timed event queue check failed");
// next-cycle implication
`define TEQU_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timed event queue check failed");
`else
`define TEQU_ASSERT_IMP(label, clk, rst, ante, cons)
`define TEQU_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/core/tequ_pkg.sv
// ----------------------------------------------------------------------------
// Timed event queue package
// Shared constants, request codes and the entry and cell control types.
// ----------------------------------------------------------------------------
package tequ_pkg;

   localparam int DEPTH_DEFAULT = 16;
   // most events fired by one poll
   localparam int MAX_RESULTS   = 16;

   localparam logic CMD_SCHEDULE = 1'b0;
   localparam logic CMD_POLL     = 1'b1;

   localparam logic [1:0] RT_ACCEPTED = 2'd0;
   localparam logic [1:0] RT_DROPPED  = 2'd1;
   localparam logic [1:0] RT_FIRED    = 2'd2;
   localparam logic [1:0] RT_NONE_DUE = 2'd3;

   // one stored event
   typedef struct packed {
      logic [63:0]        due_time;
      logic               kind;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [7:0]         key_code;
      logic               pressed;
   } entry_type;

   // per-cell control: shift toward head, load the push entry
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage

### rtl/core/tequ_cell.sv
// ----------------------------------------------------------------------------
// Timed event queue cell
// One slot of the event chain: holds, takes its neighbor's entry, or loads.
// ----------------------------------------------------------------------------
module tequ_cell
   import tequ_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  entry_type     nbr_entry,
   input  entry_type     push_entry,
   output entry_type     entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // load wins over shift
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift) begin
         entry_in = nbr_entry;
      end
      if (ctrl.load) begin
         entry_in = push_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

### rtl/core/timed_event_queue_unit.sv
// A schedule request gives its result in the cycle after acceptance.
// A poll makes two passes over the N stored events: the first counts the due
// events at the chain head, the second fires them one per cycle unless the
// result side stalls; none due answers after the first pass, empty as a schedule does.
// Throughput: one request at a time, set by the single head compare/sequencer.
// Reset (synchronous): queue empty, sequencer idle, no result pending.
// ----------------------------------------------------------------------------
// Timed event queue unit
// Shift-register chain of event cells with a head sequencer for schedule/poll.
// ----------------------------------------------------------------------------
module timed_event_queue_unit
   import tequ_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic [63:0]        req_time_req,
   input  logic               req_event_kind_in,
   input  logic signed [15:0] req_pos_x_in,
   input  logic signed [15:0] req_pos_y_in,
   input  logic [7:0]         req_key_code_in,
   input  logic               req_pressed_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_result_type,
   output logic               rsp_event_kind,
   output logic signed [15:0] rsp_pos_x,
   output logic signed [15:0] rsp_pos_y,
   output logic [7:0]         rsp_key_code,
   output logic               rsp_pressed,
   output logic               rsp_last,
   output logic [4:0]         rsp_pending_count
);

`include "timed_event_queue_unit_assert.svh"

   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_COUNT = 2'd1;
   localparam logic [1:0] S_EMIT  = 2'd2;
   localparam logic [1:0] S_NONE  = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] scan_ff,  scan_in;
   logic [CW-1:0] due_ff,   due_in;
   logic [CW-1:0] fired_ff, fired_in;
   logic [63:0]   time_ff,  time_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_type_ff, rsp_type_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic signed [15:0] rsp_x_ff, rsp_x_in;
   logic signed [15:0] rsp_y_ff, rsp_y_in;
   logic [7:0]         rsp_code_ff, rsp_code_in;
   logic               rsp_pressed_ff, rsp_pressed_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [CW-1:0]      rsp_count_ff, rsp_count_in;

   entry_type     cell_q [DEPTH];
   cell_ctrl_type cell_ctrl [DEPTH];
   entry_type     req_entry;
   entry_type     push_entry;
   entry_type     head;
   logic          shift;
   logic          push;
   logic [CW-1:0] wr_idx;
   logic          out_free;
   logic          req_acc;
   logic          head_due;
   logic          fire;
   logic          rsp_load;
   logic          scan_end;
   logic          sched_acc;
   logic          scanning;

   assign req_entry = '{due_time: req_time_req, kind: req_event_kind_in,
                        pos_x: req_pos_x_in, pos_y: req_pos_y_in,
                        key_code: req_key_code_in, pressed: req_pressed_in};

   assign head     = cell_q[0];
   assign head_due = head.due_time <= time_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign req_acc  = req_valid && !req_stall;
   assign scan_end = scan_ff == CW'(count_ff - 1'b1);
   assign fire     = head_due && (fired_ff < due_ff);

   // cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type nbr;
      if (i == DEPTH - 1) begin : g_tail
         assign nbr = cell_q[i];
      end else begin : g_mid
         assign nbr = cell_q[i + 1];
      end
      assign cell_ctrl[i] = '{shift: shift, load: push && (wr_idx == CW'(i))};
      tequ_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[i]),
         .nbr_entry  (nbr),
         .push_entry (push_entry),
         .entry      (cell_q[i])
      );
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      scan_in    = scan_ff;
      due_in     = due_ff;
      fired_in   = fired_ff;
      time_in    = time_ff;
      shift      = 1'b0;
      push       = 1'b0;
      wr_idx     = count_ff;
      push_entry = req_entry;
      rsp_load       = 1'b0;
      rsp_type_in    = RT_ACCEPTED;
      rsp_kind_in    = 1'b0;
      rsp_x_in       = '0;
      rsp_y_in       = '0;
      rsp_code_in    = '0;
      rsp_pressed_in = 1'b0;
      rsp_last_in    = 1'b1;
      rsp_count_in   = count_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_command == CMD_SCHEDULE) begin
                  rsp_load = 1'b1;
                  if (count_ff < DEPTH) begin
                     push         = 1'b1;
                     count_in     = CW'(count_ff + 1'b1);
                     rsp_count_in = CW'(count_ff + 1'b1);
                  end else begin
                     rsp_type_in = RT_DROPPED;
                  end
               end else begin
                  time_in = req_time_req;
                  scan_in = '0;
                  due_in  = '0;
                  fired_in = '0;
                  if (count_ff == '0) begin
                     rsp_load    = 1'b1;
                     rsp_type_in = RT_NONE_DUE;
                  end else begin
                     state_in = S_COUNT;
                  end
               end
            end
         end
         S_COUNT: begin
            // rotate head to tail, counting due events
            shift      = 1'b1;
            push       = 1'b1;
            wr_idx     = CW'(count_ff - 1'b1);
            push_entry = head;
            if (head_due && (32'(due_ff) < MAX_RESULTS)) begin
               due_in = CW'(due_ff + 1'b1);
            end
            scan_in = CW'(scan_ff + 1'b1);
            if (scan_end) begin
               scan_in  = '0;
               state_in = (due_in == '0) ? S_NONE : S_EMIT;
            end
         end
         S_EMIT: begin
            // pop head: fire it or put it back behind the survivors
            push_entry = head;
            wr_idx     = CW'(count_ff - fired_ff - 1'b1);
            if (!fire || out_free) begin
               shift   = 1'b1;
               scan_in = CW'(scan_ff + 1'b1);
               if (fire) begin
                  rsp_load       = 1'b1;
                  rsp_type_in    = RT_FIRED;
                  rsp_kind_in    = head.kind;
                  rsp_x_in       = head.pos_x;
                  rsp_y_in       = head.pos_y;
                  rsp_code_in    = head.key_code;
                  rsp_pressed_in = head.pressed;
                  rsp_last_in    = CW'(fired_ff + 1'b1) == due_ff;
                  rsp_count_in   = CW'(count_ff - due_ff);
                  fired_in       = CW'(fired_ff + 1'b1);
               end else begin
                  push = 1'b1;
               end
               if (scan_end) begin
                  count_in = CW'(count_ff - due_ff);
                  state_in = S_IDLE;
               end
            end
         end
         S_NONE: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_type_in = RT_NONE_DUE;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         scan_ff      <= '0;
         due_ff       <= '0;
         fired_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_ff      <= scan_in;
         due_ff       <= due_in;
         fired_ff     <= fired_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      time_ff <= time_in;
      if (rsp_load) begin
         rsp_type_ff    <= rsp_type_in;
         rsp_kind_ff    <= rsp_kind_in;
         rsp_x_ff       <= rsp_x_in;
         rsp_y_ff       <= rsp_y_in;
         rsp_code_ff    <= rsp_code_in;
         rsp_pressed_ff <= rsp_pressed_in;
         rsp_last_ff    <= rsp_last_in;
         rsp_count_ff   <= rsp_count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_type   = rsp_type_ff;
   assign rsp_event_kind    = rsp_kind_ff;
   assign rsp_pos_x         = rsp_x_ff;
   assign rsp_pos_y         = rsp_y_ff;
   assign rsp_key_code      = rsp_code_ff;
   assign rsp_pressed       = rsp_pressed_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_pending_count = 5'(rsp_count_ff);

   // checks
   assign sched_acc = req_acc && (req_command == CMD_SCHEDULE);
   assign scanning  = (state_ff == S_COUNT) || (state_ff == S_EMIT);

   `TEQU_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH)
   `TEQU_ASSERT_NXT(a_sched_result, clock, reset, sched_acc, rsp_valid_ff && rsp_last_ff)
   `TEQU_ASSERT_IMP(a_fire_bound, clock, reset, state_ff == S_EMIT, fired_ff <= due_ff)
   `TEQU_ASSERT_IMP(a_scan_bound, clock, reset, scanning, scan_ff < count_ff)

endmodule
